>>> hw/rtl/bmp_rle_pixel_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap RLE pixel decoder
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define BMP_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMPRLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMPRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bmprle_pkg.sv
// ----------------------------------------------------------------------------
// bmprle_pkg
// Types and constants shared by the front parser, command queue and back end.
// ----------------------------------------------------------------------------
package bmprle_pkg;

  localparam int PIXELS_PER_RESULT = 4;
  // A result has four pixel fields, so a run group never exceeds four.
  localparam int GROUP_SIZE = (PIXELS_PER_RESULT > 4) ? 4 : PIXELS_PER_RESULT;
  localparam int CMD_DEPTH_DEFAULT = 4;

  localparam logic [7:0] NIBBLE_MASK = 8'h0f;

  // Escape codes that follow a zero count byte.
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_SECOND,
    PH_ABS,
    PH_PAD,
    PH_DELTA
  } phase_t;

  // One unit of work for the back end. Even-indexed pixels take pix_even,
  // odd-indexed pixels take pix_odd. A count of zero is a bare mark.
  typedef struct packed {
    logic [7:0] pix_even;
    logic [7:0] pix_odd;
    logic [7:0] count;
    logic       eol;
    logic       eob;
  } cmd_t;

endpackage

>>> hw/rtl/bmprle_front.sv
// ----------------------------------------------------------------------------
// bmprle_front
// Byte parser: tracks the stream phase and turns pixel-producing bytes and
// line or bitmap marks into commands for the back end.
// ----------------------------------------------------------------------------
module bmprle_front
  import bmprle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       rle_mode,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t     phase, phase_next;
  logic [7:0] held_count, held_count_next;
  logic [7:0] abs_rem, abs_rem_next;
  logic       pad_pending, pad_pending_next;
  logic [1:0] skip_rem, skip_rem_next;

  logic [7:0] abs_n;
  logic [8:0] abs_total;
  logic [8:0] abs_data;

  // Pixels carried by one absolute data byte, limited by what is left.
  always_comb begin
    if (rle_mode) begin
      abs_n = (abs_rem >= 8'd2) ? 8'd2 : 8'd1;
    end else begin
      abs_n = 8'd1;
    end
    if (abs_n > abs_rem) begin
      abs_n = abs_rem;
    end
  end

  assign abs_total = ((({1'b0, data_byte}) + 9'd3) >> 1) & ~9'd1;
  assign abs_data  = (({1'b0, data_byte}) + 9'd1) >> 1;

  always_comb begin
    phase_next       = phase;
    held_count_next  = held_count;
    abs_rem_next     = abs_rem;
    pad_pending_next = pad_pending;
    skip_rem_next    = skip_rem;
    if (accept) begin
      case (phase)
        PH_SECOND: begin
          phase_next = PH_COUNT;
          if (held_count == 8'd0) begin
            if (data_byte == ESC_DELTA) begin
              skip_rem_next = 2'd2;
              phase_next    = PH_DELTA;
            end else if (data_byte != ESC_EOL && data_byte != ESC_EOB) begin
              abs_rem_next = data_byte;
              if (rle_mode) begin
                pad_pending_next = (abs_total > abs_data);
              end else begin
                pad_pending_next = data_byte[0];
              end
              phase_next = PH_ABS;
            end
          end
        end
        PH_ABS: begin
          abs_rem_next = abs_rem - abs_n;
          if (abs_rem == abs_n) begin
            phase_next = pad_pending ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_COUNT;
        end
        PH_DELTA: begin
          if (skip_rem != 2'd0) begin
            skip_rem_next = skip_rem - 2'd1;
          end
          if (skip_rem <= 2'd1) begin
            phase_next = PH_COUNT;
          end
        end
        default: begin
          held_count_next = data_byte;
          phase_next      = PH_SECOND;
        end
      endcase
    end
  end

  always_comb begin
    cmd_push = 1'b0;
    cmd      = '0;
    case (phase)
      PH_SECOND: begin
        if (held_count != 8'd0) begin
          cmd_push  = accept;
          cmd.count = held_count;
          if (rle_mode) begin
            cmd.pix_even = (data_byte >> 4) & NIBBLE_MASK;
            cmd.pix_odd  = data_byte & NIBBLE_MASK;
          end else begin
            cmd.pix_even = data_byte;
            cmd.pix_odd  = data_byte;
          end
        end else if (data_byte == ESC_EOL) begin
          cmd_push = accept;
          cmd.eol  = 1'b1;
        end else if (data_byte == ESC_EOB) begin
          cmd_push = accept;
          cmd.eob  = 1'b1;
        end
      end
      PH_ABS: begin
        cmd_push  = accept;
        cmd.count = abs_n;
        if (rle_mode) begin
          cmd.pix_even = (data_byte >> 4) & NIBBLE_MASK;
          cmd.pix_odd  = data_byte & NIBBLE_MASK;
        end else begin
          cmd.pix_even = data_byte;
        end
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      held_count  <= 8'd0;
      abs_rem     <= 8'd0;
      pad_pending <= 1'b0;
      skip_rem    <= 2'd0;
    end else begin
      phase       <= phase_next;
      held_count  <= held_count_next;
      abs_rem     <= abs_rem_next;
      pad_pending <= pad_pending_next;
      skip_rem    <= skip_rem_next;
    end
  end

endmodule

>>> hw/rtl/bmprle_cmdq.sv
// ----------------------------------------------------------------------------
// bmprle_cmdq
// Small first-in first-out queue of commands between parser and back end.
// A read loads the oldest command into an output register, which holds it
// until the next read.
// ----------------------------------------------------------------------------
module bmprle_cmdq
  import bmprle_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH_DEFAULT  // two or more entries
)
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(DEPTH));
  assign q_empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
    if (rd_en) begin
      rd_cmd <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/bmprle_back.sv
// ----------------------------------------------------------------------------
// bmprle_back
// Expands one command at a time into result groups and holds the result
// in an output register until it is popped.
// ----------------------------------------------------------------------------
`include "bmp_rle_pixel_decoder_core_defines.svh"

module bmprle_back
  import bmprle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] pixel_a,
  output logic [7:0] pixel_b,
  output logic [7:0] pixel_c,
  output logic [7:0] pixel_d,
  output logic [2:0] pixel_count,
  output logic       end_of_line,
  output logic       end_of_bitmap,
  output logic       last_of_run
);

  localparam logic [7:0] GROUP8 = 8'(GROUP_SIZE);

  logic       busy;
  logic [7:0] pix_even;
  logic [7:0] pix_odd;
  logic [7:0] sent;
  logic [7:0] rem;
  logic       eol;
  logic       eob;

  logic       out_valid;
  logic [7:0] out_pix [4];
  logic [2:0] out_count;
  logic       out_eol;
  logic       out_eob;
  logic       out_last;

  logic       emit;
  logic       slot_free;
  logic [7:0] grp_n;
  logic       grp_last;
  logic [7:0] grp_pix [4];

  assign slot_free = !out_valid || pop;
  assign emit      = busy && slot_free;
  assign q_pop     = !busy && !q_empty;

  // The queue's read register holds the current command from the cycle
  // after the pop until the command is finished.
  assign pix_even = q_cmd.pix_even;
  assign pix_odd  = q_cmd.pix_odd;
  assign eol      = q_cmd.eol;
  assign eob      = q_cmd.eob;
  assign rem      = q_cmd.count - sent;

  assign grp_last = (rem <= GROUP8);
  assign grp_n    = grp_last ? rem : GROUP8;

  // Each group starts at an even pixel index, so parity follows the lane.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (8'(i) < grp_n) begin
        grp_pix[i] = i[0] ? pix_odd : pix_even;
      end else begin
        grp_pix[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sent <= 8'd0;
    end else if (emit) begin
      sent <= sent + grp_n;
    end
    if (emit) begin
      out_pix   <= grp_pix;
      out_count <= grp_n[2:0];
      out_eol   <= eol;
      out_eob   <= eob;
      out_last  <= grp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && grp_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty         = !out_valid;
  assign pixel_a       = out_pix[0];
  assign pixel_b       = out_pix[1];
  assign pixel_c       = out_pix[2];
  assign pixel_d       = out_pix[3];
  assign pixel_count   = out_count;
  assign end_of_line   = out_eol;
  assign end_of_bitmap = out_eob;
  assign last_of_run   = out_last;

  `BMPRLE_ASSERT_SAME(a_mark_single, out_valid && (out_eol || out_eob),
    out_count == 3'd0 && out_last, "mark result must be empty and last")
  `BMPRLE_ASSERT_SAME(a_full_group, out_valid && !out_last,
    out_count == 3'(GROUP_SIZE), "non-final group must be full")
  `BMPRLE_ASSERT_SAME(a_load_idle, q_pop, !busy, "command loaded while busy")
  `BMPRLE_ASSERT_NEXT(a_load_busy, q_pop, busy, "loaded command not started")

endmodule

>>> hw/rtl/bmp_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp_rle_pixel_decoder_core
// Bitmap RLE8 / RLE4 stream decoder producing palette index groups.
// ----------------------------------------------------------------------------
// Usage:
//   Compressed bytes enter on data_byte; an item is taken at a clock edge
//   with push high and full low. Results leave like a queue: while empty is
//   low the oldest result sits on the pixel and flag ports, and it is taken
//   at an edge with pop high. rle_mode is written through cfg_write and
//   cfg_data while the decoder is idle.
// Timing:
//   The parser takes one byte per cycle while its command queue has room.
//   A byte that produces pixels leaves a command; if the back end is idle,
//   the queue's read register loads it and its first result then enters
//   the output register once that is free. The back end takes a command
//   only while idle and emits one result per group of up to four pixels;
//   an absolute byte or a line or bitmap mark gives one result. It thus
//   sets the sustained rate; count, escape, delta and pad bytes add no work.
// Stalls and reset:
//   A result that is not popped stays in the output register; the back end
//   then halts, the command queue fills, and full is raised. Reset empties
//   the queue and output register, returns the parser to expecting a count
//   byte, and sets rle_mode to 8-bit mode.
// ----------------------------------------------------------------------------
module bmp_rle_pixel_decoder_core
  import bmprle_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] pixel_a,
  output logic [7:0] pixel_b,
  output logic [7:0] pixel_c,
  output logic [7:0] pixel_d,
  output logic [2:0] pixel_count,
  output logic       end_of_line,
  output logic       end_of_bitmap,
  output logic       last_of_run
);

  logic rle_mode;
  logic accept;
  logic cmd_push;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // Mode register: each byte is decoded in the mode in force on arrival.
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode <= 1'b0;
    end else if (cfg_write) begin
      rle_mode <= cfg_data;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  bmprle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .rle_mode  (rle_mode),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd)
  );

  bmprle_cmdq #(
    .DEPTH (CMD_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (front_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (q_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bmprle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_cmd         (q_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .pixel_a       (pixel_a),
    .pixel_b       (pixel_b),
    .pixel_c       (pixel_c),
    .pixel_d       (pixel_d),
    .pixel_count   (pixel_count),
    .end_of_line   (end_of_line),
    .end_of_bitmap (end_of_bitmap),
    .last_of_run   (last_of_run)
  );

endmodule

>>> tb/sv/bmp_rle_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp_rle_decode_checker
// Watches the byte and pixel group channels of the bitmap RLE decoder, keeps
// its own decode of the byte stream and compares every popped group with it.
// ----------------------------------------------------------------------------
module bmp_rle_decode_checker
  import bmprle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] pixel_a,
  input  logic [7:0] pixel_b,
  input  logic [7:0] pixel_c,
  input  logic [7:0] pixel_d,
  input  logic [2:0] pixel_count,
  input  logic       end_of_line,
  input  logic       end_of_bitmap,
  input  logic       last_of_run,
  output int         mismatches,
  output int         outstanding,
  output int         groups_checked
);

  typedef struct packed {
    logic [3:0][7:0] pix;
    logic [2:0]      count;
    logic            eol;
    logic            eob;
    logic            last;
  } pixel_group_t;

  pixel_group_t expected_groups[$];

  // Decoder state as the stream has left it so far.
  logic       mode_4bit;
  phase_t     phase;
  logic [7:0] run_length;
  logic [7:0] abs_left;
  logic       pad_due;
  logic [1:0] offsets_left;
  int         errors = 0;
  int         checked = 0;

  // A run is split into groups of GROUP_SIZE pixels; in 4-bit mode the pixels
  // alternate high and low nibble, counted from the start of the run.
  task automatic queue_run(input logic [7:0] length, input logic [7:0] value);
    pixel_group_t grp;
    int done;
    int n;
    done = 0;
    while (done < length) begin
      grp = '0;
      n = length - done;
      if (n > GROUP_SIZE) n = GROUP_SIZE;
      for (int i = 0; i < n; i++) begin
        if (!mode_4bit) grp.pix[i] = value;
        else if ((done + i) % 2 == 1) grp.pix[i] = value & NIBBLE_MASK;
        else grp.pix[i] = {4'h0, value[7:4]};
      end
      grp.count = 3'(n);
      done += n;
      grp.last = (done >= length);
      expected_groups.push_back(grp);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    pixel_group_t grp;
    logic [8:0]   data_bytes;
    grp = '0;
    case (phase)
      PH_SECOND: begin
        phase = PH_COUNT;
        if (run_length != 8'd0) begin
          queue_run(run_length, b);
        end else if (b == ESC_EOL) begin
          grp.eol = 1'b1;
          grp.last = 1'b1;
          expected_groups.push_back(grp);
        end else if (b == ESC_EOB) begin
          grp.eob = 1'b1;
          grp.last = 1'b1;
          expected_groups.push_back(grp);
        end else if (b == ESC_DELTA) begin
          offsets_left = 2'd2;
          phase = PH_DELTA;
        end else begin
          // Absolute data; the stream pads it to an even number of bytes,
          // and the pad is decided here in the mode of this byte.
          abs_left = b;
          data_bytes = (9'(b) + 9'd1) >> 1;
          pad_due = mode_4bit ? data_bytes[0] : b[0];
          phase = PH_ABS;
        end
      end
      PH_ABS: begin
        if (mode_4bit && abs_left >= 8'd2) begin
          grp.pix[0] = {4'h0, b[7:4]};
          grp.pix[1] = b & NIBBLE_MASK;
          grp.count = 3'd2;
        end else begin
          grp.pix[0] = mode_4bit ? {4'h0, b[7:4]} : b;
          grp.count = 3'd1;
        end
        abs_left = abs_left - 8'(grp.count);
        grp.last = 1'b1;
        if (abs_left == 8'd0) phase = pad_due ? PH_PAD : PH_COUNT;
        expected_groups.push_back(grp);
      end
      PH_PAD: begin
        pad_due = 1'b0;
        phase = PH_COUNT;
      end
      PH_DELTA: begin
        if (offsets_left != 2'd0) offsets_left--;
        if (offsets_left == 2'd0) phase = PH_COUNT;
      end
      default: begin
        run_length = b;
        phase = PH_SECOND;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_group();
    pixel_group_t want;
    if (expected_groups.size() == 0) begin
      $error("pixel group popped with none expected (pixel_count %0d)", pixel_count);
      errors++;
      return;
    end
    want = expected_groups.pop_front();
    checked++;
    compare_field("pixel_a", want.pix[0], pixel_a);
    compare_field("pixel_b", want.pix[1], pixel_b);
    compare_field("pixel_c", want.pix[2], pixel_c);
    compare_field("pixel_d", want.pix[3], pixel_d);
    compare_field("pixel_count", 8'(want.count), 8'(pixel_count));
    compare_field("end_of_line", 8'(want.eol), 8'(end_of_line));
    compare_field("end_of_bitmap", 8'(want.eob), 8'(end_of_bitmap));
    compare_field("last_of_run", 8'(want.last), 8'(last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_4bit = 1'b0;
      phase = PH_COUNT;
      run_length = 8'd0;
      abs_left = 8'd0;
      pad_due = 1'b0;
      offsets_left = 2'd0;
      expected_groups.delete();
    end else begin
      if (cfg_write) mode_4bit = cfg_data;
      if (push && !full) decode_byte(data_byte);
      if (pop && !empty) check_group();
    end
    mismatches <= errors;
    outstanding <= expected_groups.size();
    groups_checked <= checked;
  end

endmodule

>>> tb/sv/tb_bmp_rle_pixel_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp_rle_pixel_decoder_core
// Feeds RLE8 and RLE4 byte streams into the decoder under random back-pressure
// and lets the checker compare every pixel group against its own decode.
// ----------------------------------------------------------------------------
module tb_bmp_rle_pixel_decoder_core
  import bmprle_pkg::*;
();

  localparam int     HALF_PERIOD_NS = 6;
  // Four random segments of at least this many bytes, one register write each.
  localparam int     SEGMENT_ITEMS = 80;
  // Cycles allowed after the last expected group before the decoder counts as
  // idle; covers the back end's registers and a byte still in the parser.
  localparam int     QUIET_CYCLES = 8;
  // Length of the one long receiver stall that forces the input to fill up.
  localparam int     LONG_HOLD = 120;
  localparam longint TIMEOUT_NS = 10_000_000;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       pop;
  logic       empty;
  logic [7:0] pixel_a;
  logic [7:0] pixel_b;
  logic [7:0] pixel_c;
  logic [7:0] pixel_d;
  logic [2:0] pixel_count;
  logic       end_of_line;
  logic       end_of_bitmap;
  logic       last_of_run;

  int mismatches;
  int outstanding;
  int groups_checked;

  // idle_on and hold_request are shared by the byte sender and the group
  // receiver. idle_on enables random gaps on both sides; hold_request asks
  // the receiver for one long stall, which it counts out on its own.
  logic idle_on = 1'b1;
  int   hold_request = 0;
  logic cur_mode = 1'b0;
  int   bytes_sent = 0;

  bmp_rle_pixel_decoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .pop          (pop),
    .empty        (empty),
    .pixel_a      (pixel_a),
    .pixel_b      (pixel_b),
    .pixel_c      (pixel_c),
    .pixel_d      (pixel_d),
    .pixel_count  (pixel_count),
    .end_of_line  (end_of_line),
    .end_of_bitmap(end_of_bitmap),
    .last_of_run  (last_of_run)
  );

  bmp_rle_decode_checker decode_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .pop           (pop),
    .empty         (empty),
    .pixel_a       (pixel_a),
    .pixel_b       (pixel_b),
    .pixel_c       (pixel_c),
    .pixel_d       (pixel_d),
    .pixel_count   (pixel_count),
    .end_of_line   (end_of_line),
    .end_of_bitmap (end_of_bitmap),
    .last_of_run   (last_of_run),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .groups_checked(groups_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD_NS) clk = ~clk;
  end

  // Offers one byte and returns at the edge where it is taken. push is left
  // high so that back-to-back bytes keep it asserted; anything that lets time
  // pass afterwards without a new byte must lower it first.
  task automatic push_byte(input logic [7:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // A count byte and a value byte; the count must be nonzero or it would be
  // an escape.
  task automatic send_run(input logic [7:0] length, input logic [7:0] value);
    push_byte(length);
    push_byte(value);
  endtask

  // Stops offering bytes and waits until every expected group has been popped,
  // then lets the decoder settle so that a register write sees it idle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_write <= 1'b1;
    cfg_data <= mode;
    cur_mode = mode;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver: pops every cycle except during short random stalls and the one
  // long stall that the sender asks for.
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int   seg_start;
    int   pick;
    int   length;
    int   data_count;
    logic paused;

    rst <= 1'b1;
    push <= 1'b0;
    data_byte <= 8'd0;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // Directed part, 8-bit mode first. The shortest run, then the longest run
    // with an all-ones value; nothing is clipped to a line width.
    send_run(8'd1, 8'h00);
    send_run(8'd255, 8'hff);
    // End of line, then a delta whose offset bytes must stay silent.
    push_byte(8'h00);
    push_byte(ESC_EOL);
    push_byte(8'h00);
    push_byte(ESC_DELTA);
    push_byte(8'hff);
    push_byte(8'h00);
    // Odd absolute data: three pixels and a pad byte that emits nothing.
    push_byte(8'h00);
    push_byte(8'd3);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h80);
    push_byte(8'h77);
    push_byte(8'h00);
    push_byte(ESC_EOB);

    // Mode change in the middle of absolute data: five pixels begun in 8-bit
    // mode (so a pad is owed), finished in 4-bit mode where the last byte has
    // only one pixel left and gives just its high nibble.
    push_byte(8'h00);
    push_byte(8'd5);
    push_byte(8'h12);
    push_byte(8'h34);
    drain();
    write_mode(1'b1);
    push_byte(8'hab);
    push_byte(8'hcd);
    push_byte(8'h00);
    // An odd-length run in 4-bit mode alternates high and low nibble.
    send_run(8'd3, 8'ha5);

    // Random part in four segments, alternating the mode. Most of the traffic
    // is well-formed commands with random content; a tenth is loose bytes
    // that knock the parser out of step.
    for (int seg = 0; seg < 4; seg++) begin
      drain();
      write_mode(seg % 2 == 1);
      // The last segment runs with no idling on either side.
      idle_on = (seg < 3);
      if (seg == 1) begin
        // The receiver stalls for a long time while runs keep coming, so the
        // command queue fills and full holds the sender off.
        hold_request = LONG_HOLD;
        repeat (6) send_run(8'($urandom_range(12, 40)), 8'($urandom));
      end
      seg_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - seg_start < SEGMENT_ITEMS) begin
        if (seg == 2 && !paused && bytes_sent - seg_start >= SEGMENT_ITEMS / 2) begin
          // Sender pauses mid-segment until every expected group is out.
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Mostly short runs, now and then one of any length.
          length = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 12);
          send_run(8'(length), 8'($urandom));
        end else if (pick < 65) begin
          length = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255)
                                                : $urandom_range(3, 12);
          push_byte(8'h00);
          push_byte(8'(length));
          // In 4-bit mode each byte holds two pixels; the stream pads an odd
          // number of data bytes to an even one.
          data_count = cur_mode ? (length + 1) / 2 : length;
          repeat (data_count) push_byte(8'($urandom));
          if (data_count % 2 == 1) push_byte(8'($urandom));
        end else if (pick < 75) begin
          push_byte(8'h00);
          push_byte(ESC_DELTA);
          push_byte(8'($urandom));
          push_byte(8'($urandom));
        end else if (pick < 85) begin
          push_byte(8'h00);
          push_byte(ESC_EOL);
        end else if (pick < 90) begin
          push_byte(8'h00);
          push_byte(ESC_EOB);
        end else begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        end
      end
    end

    drain();
    $display("Decoded %0d stream bytes into %0d checked pixel groups: runs, absolute data,",
             bytes_sent, groups_checked);
    $display("deltas, line and bitmap marks in both modes, with a mode switch and a full stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: the decoder stopped making progress.");
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bmprle_pkg.sv
hw/rtl/bmprle_front.sv
hw/rtl/bmprle_cmdq.sv
hw/rtl/bmprle_back.sv
hw/rtl/bmp_rle_pixel_decoder_core.sv
tb/sv/bmp_rle_decode_checker.sv
tb/sv/tb_bmp_rle_pixel_decoder_core.sv
